// ----- hw/rtl/cbm_pkg.sv -----
package cbm_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PRG   = 2'd2,
    OP_CHR   = 2'd3
  } op_t;

  // Mirroring change reported by a write to the mirroring register
  typedef enum logic [1:0] {
    MIRR_NONE       = 2'd0,
    MIRR_VERTICAL   = 2'd1,
    MIRR_HORIZONTAL = 2'd2
  } mirr_t;

  // Configuration register indexes
  localparam logic CFG_PRG_SIZE = 1'b0;
  localparam logic CFG_CHR_SIZE = 1'b1;

  localparam int ROM_AW   = 21;
  localparam int SIZE_W   = 5;
  localparam int CPU_AW   = 16;
  localparam int DATA_W   = 8;

  localparam logic [SIZE_W-1:0] PRG_SIZE_RST = 5'd21;
  localparam logic [SIZE_W-1:0] CHR_SIZE_RST = 5'd18;

  // Fixed PRG banks and the reset value of PRG bank 1
  localparam logic [DATA_W-1:0] BANK_SWAP_LOW  = 8'h3e;
  localparam logic [DATA_W-1:0] BANK_LAST      = 8'h3f;
  localparam logic [DATA_W-1:0] BANK1_RST      = 8'h01;

  // Register write addresses
  localparam logic [CPU_AW-1:0] A_PRG_LOW   = 16'h8000;
  localparam logic [CPU_AW-1:0] A_LAYOUT    = 16'h9000;
  localparam logic [CPU_AW-1:0] A_MIRROR    = 16'h9001;
  localparam logic [CPU_AW-1:0] A_IRQ_EN    = 16'h9003;
  localparam logic [CPU_AW-1:0] A_CNT_HI    = 16'h9005;
  localparam logic [CPU_AW-1:0] A_CNT_LO    = 16'h9006;
  localparam logic [CPU_AW-1:0] A_PRG_MID   = 16'ha000;
  // CHR bank registers sit at B000..B007
  localparam logic [CPU_AW-4:0] A_CHR_BASE  = 13'h1600;

  // Address mask for a ROM of 2**lg bytes, saturating at the output width
  function automatic logic [ROM_AW-1:0] size_mask(input logic [SIZE_W-1:0] lg);
    logic [SIZE_W-1:0] n;
    logic [ROM_AW:0]   one;
    n   = (lg > SIZE_W'(ROM_AW)) ? SIZE_W'(ROM_AW) : lg;
    one = (ROM_AW+1)'(1) << n;
    return ROM_AW'(one - (ROM_AW+1)'(1));
  endfunction

endpackage

// ----- hw/rtl/cbm_if.sv -----
// Input channel: one bus event per item
interface cbm_in_if;
  import cbm_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [CPU_AW-1:0] address;
  logic [DATA_W-1:0] value;

  modport source (output valid, op, address, value, input ready);
  modport sink   (input valid, op, address, value, output ready);
endinterface

// Result channel: one result per item
interface cbm_out_if;
  import cbm_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROM_AW-1:0] rom_address;
  logic [1:0]        mirroring_event;
  logic              irq;

  modport source (output valid, rom_address, mirroring_event, irq, input ready);
  modport sink   (input valid, rom_address, mirroring_event, irq, output ready);
endinterface

// ----- hw/rtl/cartridge_bank_mapper_with_irq.sv -----
// Channel  | Dir | Fields                               | Handshake
// in_ch    | in  | op, address, value                   | valid/ready
// out_ch   | out | rom_address, mirroring_event, irq    | valid/ready
// cfg_*    | in  | cfg_index, cfg_data                  | cfg_we, no wait
//
// Each item passes an input register, then combinational decode and bank
// lookup into the result register; one item per cycle unless out_ch stalls.
// Mapper state is updated in the same cycle the result register is loaded.
// Synchronous active-low reset clears control and mapper state.
// A stalled result holds; the input register keeps accepting while the
// result register is free or being drained.
module cartridge_bank_mapper_with_irq (
  input  logic                        clk,
  input  logic                        rst_n,
  cbm_in_if.sink                      in_ch,
  cbm_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [cbm_pkg::SIZE_W-1:0]  cfg_data
);
  import cbm_pkg::*;

  // Input register
  logic              s1_valid_r;
  logic [1:0]        s1_op_r;
  logic [CPU_AW-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_value_r;

  // Result register
  logic              out_valid_r;
  logic [ROM_AW-1:0] out_rom_r;
  logic [1:0]        out_mirr_r;
  logic              out_irq_r;

  // Config
  logic [SIZE_W-1:0] prg_size_r;
  logic [SIZE_W-1:0] chr_size_r;

  // Mapper state
  logic [DATA_W-1:0] prg_bank0_r, prg_bank0_nxt;
  logic [DATA_W-1:0] prg_bank1_r, prg_bank1_nxt;
  logic [DATA_W-1:0] prg_bank2_r, prg_bank2_nxt;
  logic [DATA_W-1:0] chr_banks_r [8];
  logic [15:0]       irq_count_r, irq_count_nxt;
  logic              irq_en_r, irq_en_nxt;
  logic              layout_r, layout_nxt;
  logic [DATA_W-1:0] last_low_r, last_low_nxt;

  logic              advance;
  logic              chr_we;
  logic [ROM_AW-1:0] rom_nxt;
  logic [1:0]        mirr_nxt;
  logic              irq_nxt;
  logic [DATA_W-1:0] prg_sel;
  logic [DATA_W-1:0] chr_sel;
  logic              low_place;
  logic              low_layout;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r    <= in_ch.op;
      s1_addr_r  <= in_ch.address;
      s1_value_r <= in_ch.value;
    end
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_size_r <= PRG_SIZE_RST;
      chr_size_r <= CHR_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_SIZE: prg_size_r <= cfg_data;
        CFG_CHR_SIZE: chr_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bank lookups
  always_comb begin
    case (s1_addr_r[14:13])
      2'd0:    prg_sel = prg_bank0_r;
      2'd1:    prg_sel = prg_bank1_r;
      2'd2:    prg_sel = prg_bank2_r;
      default: prg_sel = BANK_LAST;
    endcase
  end

  assign chr_sel = chr_banks_r[s1_addr_r[12:10]];

  // Decode and next state
  always_comb begin
    prg_bank0_nxt = prg_bank0_r;
    prg_bank1_nxt = prg_bank1_r;
    prg_bank2_nxt = prg_bank2_r;
    irq_count_nxt = irq_count_r;
    irq_en_nxt    = irq_en_r;
    layout_nxt    = layout_r;
    last_low_nxt  = last_low_r;
    chr_we        = 1'b0;
    rom_nxt       = '0;
    mirr_nxt      = MIRR_NONE;
    irq_nxt       = 1'b0;
    low_place     = 1'b0;
    low_layout    = layout_r;

    case (op_t'(s1_op_r))
      OP_TICK: begin
        if (irq_count_r != 16'd0 && irq_en_r) begin
          irq_count_nxt = irq_count_r - 16'd1;
          if (irq_count_r == 16'd1) begin
            irq_nxt    = 1'b1;
            irq_en_nxt = 1'b0;
          end
        end
      end
      OP_WRITE: begin
        if (s1_addr_r == A_PRG_LOW) begin
          last_low_nxt = s1_value_r;
          low_place    = 1'b1;
        end else if (s1_addr_r == A_PRG_MID) begin
          prg_bank1_nxt = s1_value_r;
        end else if (s1_addr_r == A_LAYOUT) begin
          layout_nxt = s1_value_r[7];
          low_layout = s1_value_r[7];
          low_place  = 1'b1;
        end else if (s1_addr_r[CPU_AW-1:3] == A_CHR_BASE) begin
          chr_we = 1'b1;
        end else if (s1_addr_r == A_MIRROR) begin
          case (s1_value_r[7:6])
            2'd0:    mirr_nxt = MIRR_VERTICAL;
            2'd2:    mirr_nxt = MIRR_HORIZONTAL;
            default: mirr_nxt = MIRR_NONE;
          endcase
        end else if (s1_addr_r == A_IRQ_EN) begin
          irq_en_nxt = s1_value_r[7];
        end else if (s1_addr_r == A_CNT_HI) begin
          irq_count_nxt = {s1_value_r, 8'h00};
        end else if (s1_addr_r == A_CNT_LO) begin
          irq_count_nxt = irq_count_r | {8'h00, s1_value_r};
        end
      end
      OP_PRG: begin
        rom_nxt = {prg_sel, s1_addr_r[12:0]} & size_mask(prg_size_r);
      end
      OP_CHR: begin
        rom_nxt = {3'b000, chr_sel, s1_addr_r[9:0]} & size_mask(chr_size_r);
      end
      default: ;
    endcase

    // Rebuild the swappable windows from the last low-bank write
    if (low_place) begin
      if (!low_layout) begin
        prg_bank0_nxt = last_low_nxt;
        prg_bank2_nxt = BANK_SWAP_LOW;
      end else begin
        prg_bank0_nxt = BANK_SWAP_LOW;
        prg_bank2_nxt = last_low_nxt;
      end
    end
  end

  // Mapper state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank0_r <= '0;
      prg_bank1_r <= BANK1_RST;
      prg_bank2_r <= BANK_SWAP_LOW;
      irq_count_r <= '0;
      irq_en_r    <= 1'b0;
      layout_r    <= 1'b0;
      last_low_r  <= '0;
    end else if (advance) begin
      prg_bank0_r <= prg_bank0_nxt;
      prg_bank1_r <= prg_bank1_nxt;
      prg_bank2_r <= prg_bank2_nxt;
      irq_count_r <= irq_count_nxt;
      irq_en_r    <= irq_en_nxt;
      layout_r    <= layout_nxt;
      last_low_r  <= last_low_nxt;
    end
  end

  // CHR bank registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chr_banks_r[i] <= '0;
    end else if (advance && chr_we) begin
      chr_banks_r[s1_addr_r[2:0]] <= s1_value_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rom_r  <= rom_nxt;
      out_mirr_r <= mirr_nxt;
      out_irq_r  <= irq_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.rom_address     = out_rom_r;
  assign out_ch.mirroring_event = out_mirr_r;
  assign out_ch.irq             = out_irq_r;

endmodule

// ----- hw/rtl/cbm_checker.sv -----
module cbm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cbm_pkg::ROM_AW-1:0]  out_rom_address,
  input logic [1:0]                  out_mirroring_event,
  input logic                        out_irq
);
  import cbm_pkg::*;

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rom_address)
      && $stable(out_mirroring_event) && $stable(out_irq))
    else $error("stalled result changed");

  // An irq comes from a tick only: no address, no mirroring report
  a_irq_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq |-> out_rom_address == '0
      && out_mirroring_event == MIRR_NONE)
    else $error("irq with other result fields set");

  // A mirroring report comes from a write only
  a_mirr_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mirroring_event != MIRR_NONE |-> out_rom_address == '0
      && out_mirroring_event != 2'd3)
    else $error("bad mirroring report");

endmodule

bind cartridge_bank_mapper_with_irq cbm_checker u_cbm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_rom_address     (out_ch.rom_address),
  .out_mirroring_event (out_ch.mirroring_event),
  .out_irq             (out_ch.irq)
);
